[sv/mmrc_pkg.sv]
package mmrc_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;

  localparam logic [63:0] RES_A_BASE_RST = 64'h0;
  localparam logic [63:0] RES_A_LEN_RST  = 64'h500;
  localparam logic [63:0] RES_B_BASE_RST = 64'h80000;
  localparam logic [63:0] RES_B_LEN_RST  = 64'h80000;

  localparam logic [1:0] REG_A_BASE = 2'd0;
  localparam logic [1:0] REG_A_LEN  = 2'd1;
  localparam logic [1:0] REG_B_BASE = 2'd2;
  localparam logic [1:0] REG_B_LEN  = 2'd3;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_FIN = 1'b1;

  localparam logic [7:0] TYPE_RAM = 8'd1;

  typedef struct packed {
    logic        cmd;
    logic [63:0] region_base;
    logic [63:0] region_length;
    logic [7:0]  region_type;
    logic [31:0] region_attr;
  } in_t;

  typedef struct packed {
    logic [63:0] piece_base;
    logic [63:0] piece_length;
    logic [7:0]  piece_type;
    logic [31:0] piece_attr;
    logic        is_summary;
    logic [5:0]  map_count;
    logic [5:0]  unusable_count;
    logic        dropped;
  } out_t;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] len;
    logic [7:0]  rtype;
    logic [31:0] attr;
  } ent_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } span_t;

  typedef struct packed {
    logic        empty;
    logic        split;
    logic [63:0] s;
    logic [63:0] e;
    logic [63:0] hs;
  } clip_res_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SC_ADDR, ST_SC_END, ST_SC_CLIP, ST_STORE, ST_POP,
    ST_FIN_RD, ST_FIN_WR, ST_RE_RD, ST_RE_LD, ST_SUMMARY
  } state_t;

  // last byte of a range, saturating at the top of the address space
  function automatic logic [63:0] last_byte(input logic [63:0] b, input logic [63:0] l);
    logic [63:0] e;
    e = b + (l - 64'd1);
    return (e < b) ? '1 : e;
  endfunction

endpackage

[sv/memory_map_range_clipper_core.sv]
// Memory map range clipper: one command at a time, busy high from accept to the summary.
// Per piece the scan walks the unusable entries, both reserved ranges, then the main entries:
// ST_SC_ADDR, ST_SC_END and, for a non-zero length, ST_SC_CLIP; then ST_STORE, and ST_POP
// if a split part waits. Finalize sorts main entries (ST_FIN_RD, ST_FIN_WR) and re-adds kept
// ones (ST_RE_RD, ST_RE_LD). The summary is registered from ST_SUMMARY, entered directly
// on a zero-length add. The next item is taken in the summary cycle; the receiver cannot stall.
// Synchronous active-low reset empties both tables and restores the reserved ranges.
module memory_map_range_clipper_core #(
  parameter int TABLE_ENTRIES = mmrc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  mmrc_pkg::in_t  in_item,
  output logic           out_valid,
  output mmrc_pkg::out_t out_item,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [63:0]    cfg_data
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int KW = $clog2(2 * TABLE_ENTRIES + 3);
  localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);
  localparam int EW = $bits(mmrc_pkg::ent_t);
  localparam int SW = $bits(mmrc_pkg::span_t);

  mmrc_pkg::state_t state_r, state_nxt;

  logic [63:0] res_a_base_r, res_a_len_r, res_b_base_r, res_b_len_r;
  logic [63:0] s_r, s_nxt, e_r, e_nxt, rs_r, rs_nxt, re_r, re_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [31:0] attr_r, attr_nxt;
  logic [CW-1:0] map_cnt_r, map_cnt_nxt, bad_cnt_r, bad_cnt_nxt;
  logic [CW-1:0] top_r, top_nxt, i_r, i_nxt, j_r, j_nxt, kc_r, kc_nxt;
  logic [KW-1:0] k_r, k_nxt, total;
  logic          empty_r, empty_nxt, drop_r, drop_nxt, fin_r, fin_nxt;
  logic          out_valid_r, out_valid_nxt;
  mmrc_pkg::out_t out_item_r, out_item_nxt;

  logic          map_we, bad_we, pend_we, keep_we;
  logic [AW-1:0] map_raddr, bad_raddr, pend_raddr, pend_waddr;
  mmrc_pkg::ent_t  map_wdata, map_rdata, keep_wdata, keep_rdata;
  mmrc_pkg::span_t bad_wdata, bad_rdata, pend_wdata, pend_rdata;
  mmrc_pkg::clip_res_t clip;

  logic [63:0] sel_b, sel_l;
  logic        keep_ok, k_end;

  mmrc_ram #(.W(EW), .D(TABLE_ENTRIES), .AW(AW)) u_map (
    .clk, .we(map_we), .waddr(AW'(map_cnt_r)), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata));

  mmrc_ram #(.W(SW), .D(TABLE_ENTRIES), .AW(AW)) u_bad (
    .clk, .we(bad_we), .waddr(AW'(bad_cnt_r)), .wdata(bad_wdata),
    .raddr(bad_raddr), .rdata(bad_rdata));

  mmrc_ram #(.W(SW), .D(TABLE_ENTRIES), .AW(AW)) u_pend (
    .clk, .we(pend_we), .waddr(pend_waddr), .wdata(pend_wdata),
    .raddr(pend_raddr), .rdata(pend_rdata));

  mmrc_ram #(.W(EW), .D(TABLE_ENTRIES), .AW(AW)) u_keep (
    .clk, .we(keep_we), .waddr(AW'(kc_r)), .wdata(keep_wdata),
    .raddr(AW'(j_r)), .rdata(keep_rdata));

  mmrc_clip u_clip (.s(s_r), .e(e_r), .rs(rs_r), .re(re_r), .res(clip));

  assign total   = KW'(bad_cnt_r) + KW'(2) + KW'(map_cnt_r);
  assign k_end   = (k_r == total);
  assign keep_ok = (map_rdata.rtype == mmrc_pkg::TYPE_RAM) && map_rdata.attr[0];

  assign busy      = (state_r != mmrc_pkg::ST_IDLE);
  assign cfg_ready = !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // range under test for scan index k
  always_comb begin
    if (k_r < KW'(bad_cnt_r)) begin
      sel_b = bad_rdata.lo;
      sel_l = bad_rdata.hi;
    end else if (k_r == KW'(bad_cnt_r)) begin
      sel_b = res_a_base_r;
      sel_l = res_a_len_r;
    end else if (k_r == KW'(bad_cnt_r) + KW'(1)) begin
      sel_b = res_b_base_r;
      sel_l = res_b_len_r;
    end else begin
      sel_b = map_rdata.base;
      sel_l = map_rdata.len;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mmrc_pkg::ST_IDLE: begin
        if (start) begin
          if (in_item.cmd == mmrc_pkg::CMD_FIN) state_nxt = mmrc_pkg::ST_FIN_RD;
          else if (in_item.region_length != '0) state_nxt = mmrc_pkg::ST_SC_ADDR;
          else state_nxt = mmrc_pkg::ST_SUMMARY;
        end
      end
      mmrc_pkg::ST_SC_ADDR:
        state_nxt = k_end ? mmrc_pkg::ST_STORE : mmrc_pkg::ST_SC_END;
      mmrc_pkg::ST_SC_END:
        state_nxt = (sel_l == '0) ? mmrc_pkg::ST_SC_ADDR : mmrc_pkg::ST_SC_CLIP;
      mmrc_pkg::ST_SC_CLIP:
        state_nxt = clip.empty ? mmrc_pkg::ST_STORE : mmrc_pkg::ST_SC_ADDR;
      mmrc_pkg::ST_STORE: begin
        if (top_r != '0) state_nxt = mmrc_pkg::ST_POP;
        else if (fin_r) state_nxt = mmrc_pkg::ST_RE_RD;
        else state_nxt = mmrc_pkg::ST_SUMMARY;
      end
      mmrc_pkg::ST_POP:    state_nxt = mmrc_pkg::ST_SC_ADDR;
      mmrc_pkg::ST_FIN_RD:
        state_nxt = (i_r == map_cnt_r) ? mmrc_pkg::ST_RE_RD : mmrc_pkg::ST_FIN_WR;
      mmrc_pkg::ST_FIN_WR: state_nxt = mmrc_pkg::ST_FIN_RD;
      mmrc_pkg::ST_RE_RD:
        state_nxt = (j_r == kc_r) ? mmrc_pkg::ST_SUMMARY : mmrc_pkg::ST_RE_LD;
      mmrc_pkg::ST_RE_LD:
        state_nxt = (keep_rdata.len != '0) ? mmrc_pkg::ST_SC_ADDR : mmrc_pkg::ST_RE_RD;
      mmrc_pkg::ST_SUMMARY: state_nxt = mmrc_pkg::ST_IDLE;
      default:              state_nxt = mmrc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_nxt = s_r;  e_nxt = e_r;  rs_nxt = rs_r;  re_nxt = re_r;
    type_nxt = type_r;  attr_nxt = attr_r;
    map_cnt_nxt = map_cnt_r;  bad_cnt_nxt = bad_cnt_r;
    top_nxt = top_r;  i_nxt = i_r;  j_nxt = j_r;  kc_nxt = kc_r;  k_nxt = k_r;
    empty_nxt = empty_r;  drop_nxt = drop_r;  fin_nxt = fin_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    map_we = 1'b0;  bad_we = 1'b0;  pend_we = 1'b0;  keep_we = 1'b0;
    map_raddr  = AW'(k_r - KW'(bad_cnt_r) - KW'(2));
    bad_raddr  = AW'(k_r);
    pend_raddr = AW'(top_r - CW'(1));
    pend_waddr = AW'(top_r);
    map_wdata  = '{base: s_r, len: e_r - s_r + 64'd1, rtype: type_r, attr: attr_r};
    bad_wdata  = '{lo: map_rdata.base, hi: map_rdata.len};
    keep_wdata = map_rdata;
    pend_wdata = '{lo: clip.hs, hi: e_r};
    case (state_r)
      mmrc_pkg::ST_IDLE: begin
        if (start) begin
          drop_nxt = 1'b0;
          if (in_item.cmd == mmrc_pkg::CMD_FIN) begin
            fin_nxt = 1'b1;
            i_nxt = '0;  kc_nxt = '0;  bad_cnt_nxt = '0;
          end else begin
            fin_nxt  = 1'b0;
            s_nxt    = in_item.region_base;
            e_nxt    = mmrc_pkg::last_byte(in_item.region_base, in_item.region_length);
            type_nxt = in_item.region_type;
            attr_nxt = in_item.region_attr;
            top_nxt = '0;  k_nxt = '0;  empty_nxt = 1'b0;
          end
        end
      end
      mmrc_pkg::ST_SC_END: begin
        if (sel_l == '0) begin
          k_nxt = k_r + KW'(1);
        end else begin
          rs_nxt = sel_b;
          re_nxt = mmrc_pkg::last_byte(sel_b, sel_l);
        end
      end
      mmrc_pkg::ST_SC_CLIP: begin
        if (clip.empty) begin
          empty_nxt = 1'b1;
        end else begin
          s_nxt = clip.s;
          e_nxt = clip.e;
          k_nxt = k_r + KW'(1);
          if (clip.split) begin
            if (top_r < FULL) begin
              pend_we = 1'b1;
              top_nxt = top_r + CW'(1);
            end else begin
              drop_nxt = 1'b1;
            end
          end
        end
      end
      mmrc_pkg::ST_STORE: begin
        if (!empty_r) begin
          if (map_cnt_r < FULL) begin
            map_we        = 1'b1;
            map_cnt_nxt   = map_cnt_r + CW'(1);
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{piece_base: s_r, piece_length: e_r - s_r + 64'd1,
                              piece_type: type_r, piece_attr: attr_r,
                              default: '0};
          end else begin
            drop_nxt = 1'b1;
          end
        end
        if (top_r != '0) top_nxt = top_r - CW'(1);
        else if (fin_r) j_nxt = j_r + CW'(1);
      end
      mmrc_pkg::ST_POP: begin
        s_nxt = pend_rdata.lo;
        e_nxt = pend_rdata.hi;
        k_nxt = '0;
        empty_nxt = 1'b0;
      end
      mmrc_pkg::ST_FIN_RD: begin
        map_raddr = AW'(i_r);
        if (i_r == map_cnt_r) begin
          map_cnt_nxt = '0;
          j_nxt = '0;
        end
      end
      mmrc_pkg::ST_FIN_WR: begin
        // usable entries wait in the keep table, the rest become unusable
        if (keep_ok) begin
          keep_we = 1'b1;
          kc_nxt  = kc_r + CW'(1);
        end else begin
          bad_we      = 1'b1;
          bad_cnt_nxt = bad_cnt_r + CW'(1);
        end
        i_nxt = i_r + CW'(1);
      end
      mmrc_pkg::ST_RE_LD: begin
        if (keep_rdata.len != '0) begin
          s_nxt    = keep_rdata.base;
          e_nxt    = mmrc_pkg::last_byte(keep_rdata.base, keep_rdata.len);
          type_nxt = keep_rdata.rtype;
          attr_nxt = keep_rdata.attr;
          top_nxt = '0;  k_nxt = '0;  empty_nxt = 1'b0;
        end else begin
          j_nxt = j_r + CW'(1);
        end
      end
      mmrc_pkg::ST_SUMMARY: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{is_summary: 1'b1, map_count: 6'(map_cnt_r),
                          unusable_count: 6'(bad_cnt_r), dropped: drop_r,
                          default: '0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mmrc_pkg::ST_IDLE;
      map_cnt_r    <= '0;
      bad_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
      res_a_base_r <= mmrc_pkg::RES_A_BASE_RST;
      res_a_len_r  <= mmrc_pkg::RES_A_LEN_RST;
      res_b_base_r <= mmrc_pkg::RES_B_BASE_RST;
      res_b_len_r  <= mmrc_pkg::RES_B_LEN_RST;
      top_r <= '0;  i_r <= '0;  j_r <= '0;  kc_r <= '0;  k_r <= '0;
      empty_r <= 1'b0;  drop_r <= 1'b0;  fin_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      map_cnt_r   <= map_cnt_nxt;
      bad_cnt_r   <= bad_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      top_r <= top_nxt;  i_r <= i_nxt;  j_r <= j_nxt;  kc_r <= kc_nxt;  k_r <= k_nxt;
      empty_r <= empty_nxt;  drop_r <= drop_nxt;  fin_r <= fin_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mmrc_pkg::REG_A_BASE: res_a_base_r <= cfg_data;
          mmrc_pkg::REG_A_LEN:  res_a_len_r  <= cfg_data;
          mmrc_pkg::REG_B_BASE: res_b_base_r <= cfg_data;
          mmrc_pkg::REG_B_LEN:  res_b_len_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;  e_r <= e_nxt;  rs_r <= rs_nxt;  re_r <= re_nxt;
    type_r <= type_nxt;  attr_r <= attr_nxt;
    out_item_r <= out_item_nxt;
  end

  a_summary_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.is_summary |-> !busy) else $error("summary while busy");

  a_map_bound: assert property (@(posedge clk) disable iff (!rst_n)
    map_cnt_r <= FULL && bad_cnt_r <= FULL && top_r <= FULL)
    else $error("table count out of range");

  a_piece_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.is_summary |-> busy) else $error("piece after command end");

endmodule

[sv/mmrc_ram.sv]
module mmrc_ram #(
  parameter int W  = 128,
  parameter int D  = 32,
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[sv/mmrc_clip.sv]
module mmrc_clip (
  input  logic [63:0]        s,
  input  logic [63:0]        e,
  input  logic [63:0]        rs,
  input  logic [63:0]        re,
  output mmrc_pkg::clip_res_t res
);

  always_comb begin
    logic [63:0] ns;
    logic [63:0] ne;
    ns = s;
    ne = e;
    res = '0;
    // trim the low end
    if (re >= ns && rs <= ns) begin
      if (re == '1) res.empty = 1'b1;
      else ns = re + 64'd1;
    end
    if (ns > ne) res.empty = 1'b1;
    // trim the high end
    if (rs <= ne && re >= ne) begin
      if (rs == '0) res.empty = 1'b1;
      else ne = rs - 64'd1;
    end
    if (ns > ne) res.empty = 1'b1;
    // range strictly inside: keep the low part, hand back the high one
    if (!res.empty && rs > ns && re < ne) begin
      res.split = 1'b1;
      res.hs    = re + 64'd1;
      ne        = rs - 64'd1;
    end
    res.s = ns;
    res.e = ne;
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int NTAB = mmrc_pkg::TABLE_ENTRIES_DEF;
  localparam int STALL_LIMIT = 200000;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  mmrc_pkg::in_t  in_item = '0;
  logic           out_valid;
  mmrc_pkg::out_t out_item;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [1:0]     cfg_index = '0;
  logic [63:0]    cfg_data = '0;

  memory_map_range_clipper_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [63:0] rsv_a_base, rsv_a_len, rsv_b_base, rsv_b_len;
  logic [63:0] tbl_base [NTAB];
  logic [63:0] tbl_len [NTAB];
  logic [7:0]  tbl_type [NTAB];
  logic [31:0] tbl_attr [NTAB];
  int          tbl_cnt;
  logic [63:0] bad_b [NTAB];
  logic [63:0] bad_l [NTAB];
  int          bad_cnt;

  mmrc_pkg::out_t expected_pieces[$];
  mmrc_pkg::in_t  pending_items[$];
  int   errors = 0;
  int   pieces_seen = 0;
  int   summaries_seen = 0;
  int   drops_seen = 0;
  int   cmds_sent = 0;
  int   idle_cycles = 0;

  function automatic logic [63:0] span_end(logic [63:0] b, logic [63:0] l);
    logic [63:0] e;
    e = b + (l - 64'd1);
    if (e < b) e = '1;
    return e;
  endfunction

  // trim or split [s,e] by [rs,re]; returns 0 kept, 1 emptied, 2 split
  function automatic int trim_span(logic [63:0] rs, logic [63:0] re,
                                   inout logic [63:0] s, inout logic [63:0] e,
                                   inout logic [63:0] hs);
    if (re >= s && rs <= s) begin
      if (re == '1) return 1;
      s = re + 64'd1;
    end
    if (s > e) return 1;
    if (rs <= e && re >= e) begin
      if (rs == 0) return 1;
      e = rs - 64'd1;
    end
    if (s > e) return 1;
    if (rs > s && re < e) begin
      hs = re + 64'd1;
      e = rs - 64'd1;
      return 2;
    end
    return 0;
  endfunction

  task automatic carve_region(logic [63:0] s, logic [63:0] e, logic [7:0] ty,
                              logic [31:0] at, inout bit lost);
    logic [63:0] stk_s [NTAB];
    logic [63:0] stk_e [NTAB];
    logic [63:0] rb, rl, hs, he;
    int top, total, k, r;
    bit gone;
    mmrc_pkg::out_t p;
    top = 0;
    forever begin
      gone = 0;
      total = bad_cnt + 2 + tbl_cnt;
      for (k = 0; k < total && !gone; k++) begin
        hs = 0;
        he = e;
        if (k < bad_cnt) begin
          rb = bad_b[k]; rl = bad_l[k];
        end else if (k == bad_cnt) begin
          rb = rsv_a_base; rl = rsv_a_len;
        end else if (k == bad_cnt + 1) begin
          rb = rsv_b_base; rl = rsv_b_len;
        end else begin
          rb = tbl_base[k - bad_cnt - 2]; rl = tbl_len[k - bad_cnt - 2];
        end
        if (rl == 0) continue;
        r = trim_span(rb, span_end(rb, rl), s, e, hs);
        if (r == 1) gone = 1;
        else if (r == 2) begin
          if (top < NTAB) begin
            stk_s[top] = hs; stk_e[top] = he; top++;
          end else lost = 1;
        end
      end
      if (!gone) begin
        if (tbl_cnt < NTAB) begin
          tbl_base[tbl_cnt] = s; tbl_len[tbl_cnt] = e - s + 64'd1;
          tbl_type[tbl_cnt] = ty; tbl_attr[tbl_cnt] = at;
          tbl_cnt++;
          p = '0;
          p.piece_base = s; p.piece_length = e - s + 64'd1;
          p.piece_type = ty; p.piece_attr = at;
          expected_pieces.push_back(p);
        end else lost = 1;
      end
      if (top == 0) break;
      top--;
      s = stk_s[top];
      e = stk_e[top];
    end
  endtask

  task automatic predict_command(mmrc_pkg::in_t it);
    logic [63:0] kb [NTAB];
    logic [63:0] kl [NTAB];
    logic [7:0]  kt [NTAB];
    logic [31:0] ka [NTAB];
    int kc, i;
    bit lost;
    mmrc_pkg::out_t sm;
    lost = 0;
    if (it.cmd == mmrc_pkg::CMD_ADD) begin
      if (it.region_length != 0)
        carve_region(it.region_base, span_end(it.region_base, it.region_length),
                     it.region_type, it.region_attr, lost);
    end else begin
      kc = 0;
      bad_cnt = 0;
      for (i = 0; i < tbl_cnt; i++) begin
        if (tbl_type[i] == mmrc_pkg::TYPE_RAM && tbl_attr[i][0]) begin
          kb[kc] = tbl_base[i]; kl[kc] = tbl_len[i];
          kt[kc] = tbl_type[i]; ka[kc] = tbl_attr[i]; kc++;
        end else begin
          bad_b[bad_cnt] = tbl_base[i]; bad_l[bad_cnt] = tbl_len[i]; bad_cnt++;
        end
      end
      tbl_cnt = 0;
      for (i = 0; i < kc; i++)
        if (kl[i] != 0) carve_region(kb[i], span_end(kb[i], kl[i]), kt[i], ka[i], lost);
    end
    sm = '0;
    sm.is_summary = 1'b1;
    sm.map_count = 6'(tbl_cnt);
    sm.unusable_count = 6'(bad_cnt);
    sm.dropped = lost;
    expected_pieces.push_back(sm);
  endtask

  // driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        predict_command(in_item);
        cmds_sent++;
      end
      if (start && busy) begin
        // hold the item until taken
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_items.size() > 0) begin
        in_item <= pending_items.pop_front();
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 8);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end else burst_left <= burst_left - 1;
      end else start <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    mmrc_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (expected_pieces.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, out_item);
        errors++;
      end else begin
        want = expected_pieces.pop_front();
        if (out_item.is_summary) summaries_seen++; else pieces_seen++;
        if (out_item.dropped) drops_seen++;
        if (out_item.piece_base !== want.piece_base) begin
          $display("%0t: piece_base expected %h actual %h", $time,
                   want.piece_base, out_item.piece_base); errors++;
        end
        if (out_item.piece_length !== want.piece_length) begin
          $display("%0t: piece_length expected %h actual %h", $time,
                   want.piece_length, out_item.piece_length); errors++;
        end
        if (out_item.piece_type !== want.piece_type) begin
          $display("%0t: piece_type expected %h actual %h", $time,
                   want.piece_type, out_item.piece_type); errors++;
        end
        if (out_item.piece_attr !== want.piece_attr) begin
          $display("%0t: piece_attr expected %h actual %h", $time,
                   want.piece_attr, out_item.piece_attr); errors++;
        end
        if (out_item.is_summary !== want.is_summary) begin
          $display("%0t: is_summary expected %b actual %b", $time,
                   want.is_summary, out_item.is_summary); errors++;
        end
        if (out_item.map_count !== want.map_count) begin
          $display("%0t: map_count expected %0d actual %0d", $time,
                   want.map_count, out_item.map_count); errors++;
        end
        if (out_item.unusable_count !== want.unusable_count) begin
          $display("%0t: unusable_count expected %0d actual %0d", $time,
                   want.unusable_count, out_item.unusable_count); errors++;
        end
        if (out_item.dropped !== want.dropped) begin
          $display("%0t: dropped expected %b actual %b", $time,
                   want.dropped, out_item.dropped); errors++;
        end
      end
    end
  end

  // watchdog: count cycles in which no item moves
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired, %0d items outstanding", $time,
               expected_pieces.size());
      $display("** memory_map_range_clipper_core: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mmrc_pkg::REG_A_BASE: rsv_a_base = val;
      mmrc_pkg::REG_A_LEN:  rsv_a_len = val;
      mmrc_pkg::REG_B_BASE: rsv_b_base = val;
      mmrc_pkg::REG_B_LEN:  rsv_b_len = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || start || busy || expected_pieces.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic mmrc_pkg::in_t make_add(logic [63:0] b, logic [63:0] l,
                                             logic [7:0] t, logic [31:0] a);
    mmrc_pkg::in_t it;
    it.cmd = mmrc_pkg::CMD_ADD; it.region_base = b; it.region_length = l;
    it.region_type = t; it.region_attr = a;
    return it;
  endfunction

  function automatic mmrc_pkg::in_t make_fin();
    mmrc_pkg::in_t it;
    it = '0;
    it.cmd = mmrc_pkg::CMD_FIN;
    it.region_base = {$urandom, $urandom};
    it.region_length = {$urandom, $urandom};
    it.region_type = 8'($urandom);
    it.region_attr = $urandom;
    return it;
  endfunction

  function automatic logic [63:0] rand_addr();
    case ($urandom_range(0, 4))
      0: return 64'($urandom_range(0, 'h200000));
      1: return {$urandom, $urandom};
      2: return 64'hFFFF_FFFF_FFFF_0000 + 64'($urandom_range(0, 'hFFFF));
      default: return 64'($urandom_range(0, 64)) << 12;
    endcase
  endfunction

  function automatic logic [63:0] rand_len();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return {$urandom, $urandom};
      2: return 64'($urandom_range(1, 16));
      default: return 64'($urandom_range(1, 64)) << 12;
    endcase
  endfunction

  // one phase: random adds, with an occasional finalize mixed in
  task automatic queue_random(int n);
    int i;
    logic [7:0] t;
    logic [31:0] a;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) pending_items.push_back(make_fin());
      else begin
        t = ($urandom_range(0, 2) != 0) ? mmrc_pkg::TYPE_RAM : 8'($urandom);
        a = $urandom;
        if ($urandom_range(0, 2) != 0) a[0] = 1'b1;
        pending_items.push_back(make_add(rand_addr(), rand_len(), t, a));
      end
    end
  endtask

  initial begin
    rsv_a_base = mmrc_pkg::RES_A_BASE_RST; rsv_a_len = mmrc_pkg::RES_A_LEN_RST;
    rsv_b_base = mmrc_pkg::RES_B_BASE_RST; rsv_b_len = mmrc_pkg::RES_B_LEN_RST;
    tbl_cnt = 0;
    bad_cnt = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero length, edges, splits, saturation, finalize
    pending_items.push_back(make_add(64'h1000, 64'd0, mmrc_pkg::TYPE_RAM, 32'h1));
    pending_items.push_back(make_add(64'h0, 64'h200000, mmrc_pkg::TYPE_RAM, 32'h1));
    pending_items.push_back(make_add(64'h0, '1, 8'hFF, 32'hFFFF_FFFE));
    pending_items.push_back(make_add('1, 64'd1, 8'h02, 32'h1));
    pending_items.push_back(make_add(64'hFFFF_FFFF_FFFF_F000, '1, mmrc_pkg::TYPE_RAM, '1));
    pending_items.push_back(make_add(64'h300000, 64'h1000, 8'h00, 32'h0));
    pending_items.push_back(make_add(64'h301000, 64'h1000, mmrc_pkg::TYPE_RAM, 32'h0));
    pending_items.push_back(make_add(64'h2FF000, 64'h10000, mmrc_pkg::TYPE_RAM, 32'h1));
    pending_items.push_back(make_fin());
    pending_items.push_back(make_add(64'h0, 64'h400000, mmrc_pkg::TYPE_RAM, 32'h1));
    pending_items.push_back(make_fin());
    pending_items.push_back(make_fin());
    wait_drained();

    // zero-length and full-span reserved ranges
    write_reg(mmrc_pkg::REG_A_BASE, 64'h1000);
    write_reg(mmrc_pkg::REG_A_LEN, 64'd0);
    write_reg(mmrc_pkg::REG_B_BASE, 64'h0);
    write_reg(mmrc_pkg::REG_B_LEN, '1);
    pending_items.push_back(make_add(64'h5000, 64'h1000, mmrc_pkg::TYPE_RAM, 32'h1));
    queue_random(20);
    wait_drained();

    write_reg(mmrc_pkg::REG_A_BASE, '1);
    write_reg(mmrc_pkg::REG_A_LEN, '1);
    write_reg(mmrc_pkg::REG_B_BASE, 64'h8000_0000);
    write_reg(mmrc_pkg::REG_B_LEN, 64'h1000);
    queue_random(110);
    wait_drained();

    // two small reserved holes to cause interior splits; random adds fill the tables
    write_reg(mmrc_pkg::REG_A_BASE, 64'h4000);
    write_reg(mmrc_pkg::REG_A_LEN, 64'h100);
    write_reg(mmrc_pkg::REG_B_BASE, 64'h9000);
    write_reg(mmrc_pkg::REG_B_LEN, 64'h100);
    queue_random(110);
    wait_drained();

    write_reg(mmrc_pkg::REG_A_BASE, mmrc_pkg::RES_A_BASE_RST);
    write_reg(mmrc_pkg::REG_A_LEN, mmrc_pkg::RES_A_LEN_RST);
    write_reg(mmrc_pkg::REG_B_BASE, {$urandom, $urandom});
    write_reg(mmrc_pkg::REG_B_LEN, {$urandom, $urandom});
    queue_random(120);
    wait_drained();

    $display("commands %0d, pieces %0d, summaries %0d, summaries with loss %0d",
             cmds_sent, pieces_seen, summaries_seen, drops_seen);
    if (errors == 0) $display("** memory_map_range_clipper_core: PASSED **");
    else $display("** memory_map_range_clipper_core: FAILED **");
    $finish;
  end

endmodule
